// ----- rtl/epcal_pkg.sv -----
// ----------------------------------------------------------------------------
// epcal_pkg
// Shared constants and tables for the epoch seconds to local calendar block:
// constant divisors, their fixed-point reciprocals and the month start table.
// ----------------------------------------------------------------------------
package epcal_pkg;

    // Field widths
    localparam int unsigned EPOCH_W = 32;
    localparam int unsigned ZONE_W  = 17;
    localparam int unsigned LOCAL_W = 33;   // non-negative local time
    localparam int unsigned DAYS_W  = 16;   // days since epoch, < 65536
    localparam int unsigned SECS_W  = 17;   // seconds of day, < 86400

    // Pipeline register stages from accepted start to result strobe
    localparam int unsigned NSTG = 8;

    localparam logic [ZONE_W-1:0] ZONE_RESET = 17'd18000;

    // Days: 86400 = 128 * 675, so divide (t >> 7) by 675.
    // Exact for 26-bit dividends since m*675 - 2^36 < 2^10.
    localparam int unsigned       DAY_SH  = 36;
    localparam logic [26:0]       RCP_DAY = 27'(((64'd1 << DAY_SH) + 64'd674) / 64'd675);

    // Hours: 3600 = 16 * 225, divide (secs >> 4) by 225 (13-bit dividend).
    localparam int unsigned       HOUR_SH  = 21;
    localparam logic [13:0]       RCP_HOUR = 14'(((64'd1 << HOUR_SH) + 64'd224) / 64'd225);

    // Minutes: 60 = 4 * 15, divide (rs >> 2) by 15 (10-bit dividend).
    localparam int unsigned       MIN_SH  = 14;
    localparam logic [10:0]       RCP_MIN = 11'(((64'd1 << MIN_SH) + 64'd14) / 64'd15);

    // Four-year cycles: 1461 days, 16-bit dividend.
    localparam int unsigned       QUAD_SH  = 27;
    localparam logic [16:0]       RCP_QUAD = 17'(((64'd1 << QUAD_SH) + 64'd1460) / 64'd1461);

    // Weekday: divide by 7, 17-bit dividend (days plus 3).
    localparam int unsigned       WEEK_SH  = 19;
    localparam logic [16:0]       RCP_WEEK = 17'(((64'd1 << WEEK_SH) + 64'd6) / 64'd7);

    // First day of year of each month (index 0..12), leap aware
    function automatic logic [8:0] month_start(input logic leap, input logic [3:0] idx);
        logic [8:0] base;
        case (idx)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            4'd11:   base = 9'd334;
            default: base = 9'd365;
        endcase
        if (leap && (idx >= 4'd2)) begin
            base = base + 9'd1;
        end
        return base;
    endfunction

endpackage

// ----- rtl/epoch_seconds_to_local_calendar_top.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_local_calendar_top
// Converts UTC epoch seconds plus a signed zone offset into broken-down local
// time through an eight-stage pipeline of constant reciprocal multiplies.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle; o_busy never rises, the pipeline
// has no stall since results cannot be held off.
// Reset (synchronous, active low) clears the stage valid bits and loads the
// zone offset with 18000 seconds.
module epoch_seconds_to_local_calendar_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_start,
    output logic                                o_busy,
    input  logic [epcal_pkg::EPOCH_W-1:0]       i_epoch_seconds,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [epcal_pkg::ZONE_W-1:0]        i_cfg_data,
    // result
    output logic                                o_valid,
    output logic [5:0]                          o_second_of_minute,
    output logic [5:0]                          o_minute_of_hour,
    output logic [4:0]                          o_hour_of_day,
    output logic [4:0]                          o_day_of_month,
    output logic [3:0]                          o_month_number,
    output logic [7:0]                          o_years_since_1900,
    output logic [2:0]                          o_weekday_number,
    output logic [8:0]                          o_day_of_year
);
    import epcal_pkg::*;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Zone offset register
    logic [ZONE_W-1:0] r_zone;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone <= ZONE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_zone <= i_cfg_data;
        end
    end

    // Valid bits travelling with the data
    logic [NSTG-1:0] r_vld;
    logic            accept;

    assign accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    assign o_valid = r_vld[NSTG-1];

    // Stage 1: add offset, clamp negative local time to zero
    logic signed [LOCAL_W:0] n1_sum;
    logic [LOCAL_W-1:0]      r1_t;

    assign n1_sum = $signed({2'b00, i_epoch_seconds})
                  + (LOCAL_W+1)'($signed(r_zone));

    always_ff @(posedge i_clk) begin
        r1_t <= n1_sum[LOCAL_W] ? '0 : n1_sum[LOCAL_W-1:0];
    end

    // Stage 2: reciprocal multiply for the day count
    logic [52:0]        r2_pd;
    logic [LOCAL_W-1:0] r2_t;

    always_ff @(posedge i_clk) begin
        r2_pd <= 53'(r1_t[LOCAL_W-1:7]) * 53'(RCP_DAY);
        r2_t  <= r1_t;
    end

    // Stage 3: days and seconds of day
    logic [DAYS_W-1:0] n3_days;
    logic [9:0]        n3_rday;
    logic [DAYS_W-1:0] r3_days;
    logic [SECS_W-1:0] r3_secs;

    assign n3_days = r2_pd[DAY_SH+DAYS_W-1:DAY_SH];
    assign n3_rday = 10'(r2_t[LOCAL_W-1:7] - 26'(n3_days) * 26'(675));

    always_ff @(posedge i_clk) begin
        r3_days <= n3_days;
        r3_secs <= {n3_rday, r2_t[6:0]};
    end

    // Stage 4: reciprocal multiplies for hour, four-year cycle and weekday
    logic [26:0]       r4_hq;
    logic [32:0]       r4_qq;
    logic [32:0]       r4_wq;
    logic [DAYS_W-1:0] r4_days;
    logic [SECS_W-1:0] r4_secs;

    always_ff @(posedge i_clk) begin
        r4_hq   <= 27'(r3_secs[SECS_W-1:4]) * 27'(RCP_HOUR);
        r4_qq   <= 33'(r3_days) * 33'(RCP_QUAD);
        r4_wq   <= 33'(17'(r3_days) + 17'd3) * 33'(RCP_WEEK);
        r4_days <= r3_days;
        r4_secs <= r3_secs;
    end

    // Stage 5: hour, seconds within hour, cycle remainder, weekday
    logic [4:0]        n5_hour;
    logic [5:0]        n5_quad;
    logic [13:0]       n5_wq;
    logic [DAYS_W-1:0] n5_w;
    logic [2:0]        n5_wd;
    logic [4:0]        r5_hour;
    logic [11:0]       r5_rs;
    logic [5:0]        r5_quad;
    logic [10:0]       r5_rem;
    logic [2:0]        r5_wday;

    assign n5_hour = r4_hq[HOUR_SH+4:HOUR_SH];
    assign n5_quad = r4_qq[QUAD_SH+5:QUAD_SH];
    assign n5_wq   = r4_wq[WEEK_SH+13:WEEK_SH];
    assign n5_w    = r4_days + 16'd3;
    assign n5_wd   = 3'(n5_w - 16'(n5_wq) * 16'd7);

    always_ff @(posedge i_clk) begin
        r5_hour <= n5_hour;
        r5_rs   <= 12'(r4_secs - 17'(n5_hour) * 17'd3600);
        r5_quad <= n5_quad;
        r5_rem  <= 11'(r4_days - 16'(n5_quad) * 16'd1461);
        r5_wday <= n5_wd + 3'd1;
    end

    // Stage 6: minute multiply; year within cycle and day of year
    logic [20:0] r6_mq;
    logic [11:0] r6_rs;
    logic [4:0]  r6_hour;
    logic [5:0]  r6_quad;
    logic [2:0]  r6_wday;
    logic [1:0]  n6_yoff;
    logic [8:0]  n6_yday;
    logic [1:0]  r6_yoff;
    logic [8:0]  r6_yday;

    // cycle starting 1970: 365, 365, 366 (leap), 365 days
    always_comb begin
        if (r5_rem < 11'd365) begin
            n6_yoff = 2'd0;
            n6_yday = 9'(r5_rem);
        end else if (r5_rem < 11'd730) begin
            n6_yoff = 2'd1;
            n6_yday = 9'(r5_rem - 11'd365);
        end else if (r5_rem < 11'd1096) begin
            n6_yoff = 2'd2;
            n6_yday = 9'(r5_rem - 11'd730);
        end else begin
            n6_yoff = 2'd3;
            n6_yday = 9'(r5_rem - 11'd1096);
        end
    end

    always_ff @(posedge i_clk) begin
        r6_mq   <= 21'(r5_rs[11:2]) * 21'(RCP_MIN);
        r6_rs   <= r5_rs;
        r6_hour <= r5_hour;
        r6_quad <= r5_quad;
        r6_wday <= r5_wday;
        r6_yoff <= n6_yoff;
        r6_yday <= n6_yday;
    end

    // Stage 7: minute and second; month index by compare against month starts
    logic [5:0] n7_min;
    logic       n7_leap;
    logic [3:0] n7_mon;
    logic [5:0] r7_sec;
    logic [5:0] r7_min;
    logic [4:0] r7_hour;
    logic [5:0] r7_quad;
    logic [2:0] r7_wday;
    logic [1:0] r7_yoff;
    logic [8:0] r7_yday;
    logic [3:0] r7_mon;

    assign n7_min  = r6_mq[MIN_SH+5:MIN_SH];
    assign n7_leap = (r6_yoff == 2'd2);

    always_comb begin
        n7_mon = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (r6_yday >= month_start(n7_leap, 4'(i))) begin
                n7_mon = 4'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r7_sec  <= 6'(r6_rs - 12'(n7_min) * 12'd60);
        r7_min  <= n7_min;
        r7_hour <= r6_hour;
        r7_quad <= r6_quad;
        r7_wday <= r6_wday;
        r7_yoff <= r6_yoff;
        r7_yday <= r6_yday;
        r7_mon  <= n7_mon;
    end

    // Stage 8: day of month, month and year into the output registers
    always_ff @(posedge i_clk) begin
        o_second_of_minute <= r7_sec;
        o_minute_of_hour   <= r7_min;
        o_hour_of_day      <= r7_hour;
        o_day_of_month     <= 5'(r7_yday - month_start(r7_yoff == 2'd2, r7_mon) + 9'd1);
        o_month_number     <= r7_mon + 4'd1;
        o_years_since_1900 <= 8'd70 + {r7_quad, 2'b00} + 8'(r7_yoff);
        o_weekday_number   <= r7_wday;
        o_day_of_year      <= r7_yday;
    end

endmodule
